// ===== src/mrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_pkg: manual reset sequencer package
// States, LED command codes, field widths and the state-to-code mapping.
// ----------------------------------------------------------------------------
package mrs_pkg;

	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned STATE_W   = 3;
	localparam int unsigned LED_W     = 2;

	localparam logic [TIMEOUT_W-1:0] PICKUP_TIMEOUT_RESET = 16'd1000;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_CHECK   = 7'b0000010,
		ST_WAITBTN = 7'b0000100,
		ST_VR1     = 7'b0001000,
		ST_PR      = 7'b0010000,
		ST_POST    = 7'b0100000,
		ST_CLEAR   = 7'b1000000
	} seq_state_t;

	// Reported state codes
	localparam logic [STATE_W-1:0] CODE_IDLE    = 3'd0;
	localparam logic [STATE_W-1:0] CODE_CHECK   = 3'd1;
	localparam logic [STATE_W-1:0] CODE_WAITBTN = 3'd2;
	localparam logic [STATE_W-1:0] CODE_VR1     = 3'd3;
	localparam logic [STATE_W-1:0] CODE_PR      = 3'd4;
	localparam logic [STATE_W-1:0] CODE_POST    = 3'd5;
	localparam logic [STATE_W-1:0] CODE_CLEAR   = 3'd6;

	// Preparatory LED commands
	typedef enum logic [LED_W-1:0] {
		LED_NONE  = 2'd0,
		LED_FLASH = 2'd1,
		LED_ON    = 2'd2,
		LED_OFF   = 2'd3
	} led_cmd_t;

	// Map a one-hot state onto its reported code
	function automatic logic [STATE_W-1:0] state_code(input seq_state_t st);
		logic [STATE_W-1:0] code;
		unique case (st)
			ST_IDLE:    code = CODE_IDLE;
			ST_CHECK:   code = CODE_CHECK;
			ST_WAITBTN: code = CODE_WAITBTN;
			ST_VR1:     code = CODE_VR1;
			ST_PR:      code = CODE_PR;
			ST_POST:    code = CODE_POST;
			ST_CLEAR:   code = CODE_CLEAR;
			default:    code = CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== src/mrs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_in_if: poll pass channel
// Valid/ready channel carrying one poll pass word of the sequencer.
// ----------------------------------------------------------------------------
interface mrs_in_if;
	logic valid;
	logic ready;
	logic command;
	logic tick;
	logic vr1_contact;
	logic pr1_contact;
	logic button_level;
	logic auto_feedback;
	logic path_select;

	modport source (
		output valid, command, tick, vr1_contact, pr1_contact,
		       button_level, auto_feedback, path_select,
		input  ready
	);

	modport sink (
		input  valid, command, tick, vr1_contact, pr1_contact,
		       button_level, auto_feedback, path_select,
		output ready
	);
endinterface

// ===== src/mrs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_out_if: sequencer result channel
// Valid/ready channel carrying state, LED command and counter pulse.
// ----------------------------------------------------------------------------
interface mrs_out_if
	import mrs_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [STATE_W-1:0] seq_state_out;
	logic [LED_W-1:0]   led_command;
	logic               count_pulse;

	modport source (
		output valid, seq_state_out, led_command, count_pulse,
		input  ready
	);

	modport sink (
		input  valid, seq_state_out, led_command, count_pulse,
		output ready
	);
endinterface

// ===== src/manual_reset_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manual_reset_sequencer_unit: manual reset sequencer of an axle-counter box
// Each poll word is latched in an input register; the next-state logic runs
// from there into the result register and the sequencer state in the same
// cycle. The unit takes one word per clock unless the result side stalls it and
// returns each result from the result register; the sequencer state and
// timeout registers close the loop directly, so back-to-back words see each
// other's updates. The pickup timeout register resets to 1000 ticks and
// should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module manual_reset_sequencer_unit
	import mrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TIMEOUT_W-1:0] cfg_wr_data,
	mrs_in_if.sink               poll,
	mrs_out_if.source            result
);

	// Stage 1 word
	logic                 valid_s1;
	logic                 command_s1;
	logic                 tick_s1;
	logic                 vr1_s1;
	logic                 pr1_s1;
	logic                 button_s1;
	logic                 autofb_s1;
	logic                 path_s1;

	// Sequencer state and settings
	seq_state_t           state_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TIMEOUT_W-1:0] pickup_q;

	// Result register
	logic                 out_valid_q;
	logic [STATE_W-1:0]   out_state_q;
	led_cmd_t             out_led_q;
	logic                 out_pulse_q;

	// Next-state logic
	seq_state_t           state_d;
	logic [TIMEOUT_W-1:0] timeout_dec;
	logic [TIMEOUT_W-1:0] timeout_d;
	led_cmd_t             led_d;
	logic                 pulse_d;
	logic                 advance;

	// Handshake: stage 1 moves on when the result register is empty or being read
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pickup_q <= PICKUP_TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			pickup_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			command_s1 <= poll.command;
			tick_s1    <= poll.tick;
			vr1_s1     <= poll.vr1_contact;
			pr1_s1     <= poll.pr1_contact;
			button_s1  <= poll.button_level;
			autofb_s1  <= poll.auto_feedback;
			path_s1    <= poll.path_select;
		end
	end

	// Tick applied before the step rule, saturating at zero
	assign timeout_dec = (tick_s1 && (timeout_q != '0)) ? timeout_q - 1'b1 : timeout_q;

	// Step rule
	always_comb begin
		state_d   = state_q;
		timeout_d = timeout_dec;
		led_d     = LED_NONE;
		pulse_d   = 1'b0;
		if (!command_s1) begin
			state_d   = ST_CHECK;
			timeout_d = '0;
		end else begin
			unique case (state_q)
				ST_CHECK: begin
					if (vr1_s1 && pr1_s1) begin
						state_d   = ST_WAITBTN;
						timeout_d = '0;
					end
				end
				ST_WAITBTN: begin
					// pressed button is ignored while auto feedback is active
					if (!button_s1 && !autofb_s1) begin
						if (!path_s1) begin
							led_d     = LED_FLASH;
							state_d   = ST_PR;
							timeout_d = pickup_q;
						end else begin
							led_d   = LED_OFF;
							state_d = ST_VR1;
						end
					end
				end
				ST_VR1: begin
					if (!vr1_s1) begin
						pulse_d = 1'b1;
						state_d = ST_CLEAR;
					end
				end
				ST_PR: begin
					if (!pr1_s1) begin
						led_d     = LED_ON;
						pulse_d   = 1'b1;
						state_d   = ST_POST;
						timeout_d = '0;
					end else if (timeout_dec == '0) begin
						led_d   = LED_OFF;
						state_d = ST_CHECK;
					end
				end
				ST_POST: begin
					if (pr1_s1) begin
						led_d     = LED_OFF;
						state_d   = vr1_s1 ? ST_CHECK : ST_CLEAR;
						timeout_d = '0;
					end
				end
				ST_CLEAR: begin
					if (button_s1) begin
						led_d     = LED_OFF;
						state_d   = ST_CHECK;
						timeout_d = '0;
					end
				end
				ST_IDLE: begin
					state_d = ST_IDLE;
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			timeout_q <= '0;
		end else if (advance) begin
			state_q   <= state_d;
			timeout_q <= timeout_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q <= state_code(state_d);
			out_led_q   <= led_d;
			out_pulse_q <= pulse_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.seq_state_out = out_state_q;
	assign result.led_command   = out_led_q;
	assign result.count_pulse   = out_pulse_q;

`ifndef NO_ASSERTIONS
	// State register always holds exactly one state
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// A running timeout only exists while waiting for the PR pickup
	a_timeout_pr: assert property (@(posedge clk) disable iff (!arst_n)
		(timeout_q != '0) |-> (state_q == ST_PR))
		else $error("timeout running outside PR pickup");

	// Counter pulse only on entry to clear or post check
	a_pulse_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_pulse_q) |->
		((out_state_q == CODE_CLEAR) || (out_state_q == CODE_POST)))
		else $error("count pulse in unexpected state");

	// An empty result register never stalls the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> poll.ready)
		else $error("input stalled with free result register");
`endif

endmodule
